>>> rtl/assert_macros.svh
// Assertion macros for the checker module of the IR frame decoder.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define IRPW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Concurrent assertion that is also checked during reset.
`define IRPW_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

>>> rtl/irpw_pkg.sv
// Package for the IR pulse-width frame decoder: payload structs, register
// map, phase and operation codes, reset values. Depends on nothing.
`default_nettype none

package irpw_pkg;

  localparam int FRAME_BITS_DEF = 32;
  localparam int TIME_BITS_DEF  = 16;

  localparam int ELAPSED_W   = 16;
  localparam int REG_W       = 16;
  localparam int BIT_TOTAL_W = 6;
  localparam int WORD_W      = 32;
  localparam int PHASE_W     = 2;
  localparam int APB_DW      = 32;
  localparam int CFG_AW      = 5;
  localparam int REG_IDX_W   = 3;

  // Receiver phase codes.
  localparam logic [PHASE_W-1:0] PH_BURST = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SPACE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DATA  = 2'd2;

  // Input operation codes.
  localparam logic OP_EDGE     = 1'b0;
  localparam logic OP_HANDOVER = 1'b1;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_GLITCH_LIMIT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AGC_MIN      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_AGC_MAX      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPACE_MIN    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPACE_MAX    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BIT_MIN      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BIT_SPLIT    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_BIT_MAX      = 3'd7;

  // Register reset values.
  localparam logic [REG_W-1:0] RST_GLITCH_LIMIT = 16'd400;
  localparam logic [REG_W-1:0] RST_AGC_MIN      = 16'd24000;
  localparam logic [REG_W-1:0] RST_AGC_MAX      = 16'd33000;
  localparam logic [REG_W-1:0] RST_SPACE_MIN    = 16'd9000;
  localparam logic [REG_W-1:0] RST_SPACE_MAX    = 16'd24000;
  localparam logic [REG_W-1:0] RST_BIT_MIN      = 16'd600;
  localparam logic [REG_W-1:0] RST_BIT_SPLIT    = 16'd3000;
  localparam logic [REG_W-1:0] RST_BIT_MAX      = 16'd9000;

  typedef struct packed {
    logic                 operation;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 timer_wrapped;
    logic                 pin_level;
  } in_t;

  typedef struct packed {
    logic                   restart_timer;
    logic                   bit_valid;
    logic                   bit_value;
    logic [BIT_TOTAL_W-1:0] bit_total;
    logic                   frame_done;
    logic [WORD_W-1:0]      frame_word;
    logic                   repeat_seen;
    logic                   repeat_delivered;
    logic                   sync_error;
    logic [PHASE_W-1:0]     receiver_phase;
  } out_t;

  typedef struct packed {
    logic [REG_W-1:0] glitch_limit;
    logic [REG_W-1:0] agc_min;
    logic [REG_W-1:0] agc_max;
    logic [REG_W-1:0] space_min;
    logic [REG_W-1:0] space_max;
    logic [REG_W-1:0] bit_min;
    logic [REG_W-1:0] bit_split;
    logic [REG_W-1:0] bit_max;
  } cfg_t;

  // Narrow receiver state flags passed between the top level and the step logic.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               done;
    logic               pending;
  } flags_t;

endpackage

`default_nettype wire

>>> rtl/irpw_cfg.sv
// Configuration register file of the IR frame decoder behind an APB-style port.
// Depends on irpw_pkg.
`default_nettype none

module irpw_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [irpw_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [irpw_pkg::APB_DW-1:0]   pwdata,
  output      logic [irpw_pkg::APB_DW-1:0]   prdata,
  output      irpw_pkg::cfg_t                cfg
);

  irpw_pkg::cfg_t                     cfg_r;
  irpw_pkg::cfg_t                     cfg_nxt;
  logic [irpw_pkg::REG_IDX_W-1:0]     idx;
  logic [irpw_pkg::REG_W-1:0]         wdata;
  logic [irpw_pkg::REG_W-1:0]         rdata;
  logic                               wr_en;

  assign idx   = paddr[irpw_pkg::CFG_AW-1:2];
  assign wdata = pwdata[irpw_pkg::REG_W-1:0];
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        irpw_pkg::REG_GLITCH_LIMIT: cfg_nxt.glitch_limit = wdata;
        irpw_pkg::REG_AGC_MIN:      cfg_nxt.agc_min      = wdata;
        irpw_pkg::REG_AGC_MAX:      cfg_nxt.agc_max      = wdata;
        irpw_pkg::REG_SPACE_MIN:    cfg_nxt.space_min    = wdata;
        irpw_pkg::REG_SPACE_MAX:    cfg_nxt.space_max    = wdata;
        irpw_pkg::REG_BIT_MIN:      cfg_nxt.bit_min      = wdata;
        irpw_pkg::REG_BIT_SPLIT:    cfg_nxt.bit_split    = wdata;
        irpw_pkg::REG_BIT_MAX:      cfg_nxt.bit_max      = wdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      irpw_pkg::REG_GLITCH_LIMIT: rdata = cfg_r.glitch_limit;
      irpw_pkg::REG_AGC_MIN:      rdata = cfg_r.agc_min;
      irpw_pkg::REG_AGC_MAX:      rdata = cfg_r.agc_max;
      irpw_pkg::REG_SPACE_MIN:    rdata = cfg_r.space_min;
      irpw_pkg::REG_SPACE_MAX:    rdata = cfg_r.space_max;
      irpw_pkg::REG_BIT_MIN:      rdata = cfg_r.bit_min;
      irpw_pkg::REG_BIT_SPLIT:    rdata = cfg_r.bit_split;
      irpw_pkg::REG_BIT_MAX:      rdata = cfg_r.bit_max;
    endcase
  end

  assign prdata = irpw_pkg::APB_DW'(rdata);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glitch_limit <= irpw_pkg::RST_GLITCH_LIMIT;
      cfg_r.agc_min      <= irpw_pkg::RST_AGC_MIN;
      cfg_r.agc_max      <= irpw_pkg::RST_AGC_MAX;
      cfg_r.space_min    <= irpw_pkg::RST_SPACE_MIN;
      cfg_r.space_max    <= irpw_pkg::RST_SPACE_MAX;
      cfg_r.bit_min      <= irpw_pkg::RST_BIT_MIN;
      cfg_r.bit_split    <= irpw_pkg::RST_BIT_SPLIT;
      cfg_r.bit_max      <= irpw_pkg::RST_BIT_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/irpw_step.sv
// Combinational next-state and result logic of the IR frame decoder for one beat.
// Depends on irpw_pkg.
`default_nettype none

module irpw_step #(
  parameter int FRAME_BITS = irpw_pkg::FRAME_BITS_DEF,
  parameter int TIME_BITS  = irpw_pkg::TIME_BITS_DEF,
  localparam int EW = (TIME_BITS < irpw_pkg::ELAPSED_W) ? TIME_BITS : irpw_pkg::ELAPSED_W,
  localparam int SW = ((FRAME_BITS + 7) / 8) * 8,
  localparam int CW = $clog2(FRAME_BITS + 1)
) (
  input  wire irpw_pkg::in_t    item,
  input  wire irpw_pkg::cfg_t   cfg,
  input  wire irpw_pkg::flags_t flags,
  input  wire logic [CW-1:0]    cnt,
  input  wire logic [SW-1:0]    frame,
  input  wire logic [EW-1:0]    mark,
  output      irpw_pkg::flags_t flags_nxt,
  output      logic [CW-1:0]    cnt_nxt,
  output      logic [SW-1:0]    frame_nxt,
  output      logic [EW-1:0]    mark_nxt,
  output      irpw_pkg::out_t   result
);

  localparam int IW = $clog2(SW);
  localparam int DW = (TIME_BITS > irpw_pkg::REG_W) ? TIME_BITS : irpw_pkg::REG_W;
  localparam int XW = (CW > irpw_pkg::BIT_TOTAL_W) ? CW : irpw_pkg::BIT_TOTAL_W;
  localparam int FW = (SW > irpw_pkg::WORD_W) ? SW : irpw_pkg::WORD_W;

  logic [EW-1:0]              e_w;
  logic [irpw_pkg::REG_W-1:0] e;
  logic [TIME_BITS-1:0]       diff;
  logic                       glitch;
  logic [IW-1:0]              pos;
  logic                       restart;
  logic                       resync;
  logic                       bvalid;
  logic                       bval;
  logic                       rpt;
  logic                       deliv;
  logic                       serr;
  logic [XW-1:0]              cnt_x;
  logic [FW-1:0]              frame_x;

  assign e_w    = item.elapsed[EW-1:0];
  assign e      = irpw_pkg::REG_W'(e_w);
  // Distance to the glitch mark wraps at the timer width.
  assign diff   = TIME_BITS'(e_w) - TIME_BITS'(mark);
  assign glitch = DW'(diff) < DW'(cfg.glitch_limit);
  // Bits land MSB-first within each byte.
  assign pos    = cnt[IW-1:0] ^ IW'(7);

  always_comb begin
    flags_nxt = flags;
    cnt_nxt   = cnt;
    frame_nxt = frame;
    mark_nxt  = mark;
    restart   = 1'b0;
    resync    = 1'b0;
    bvalid    = 1'b0;
    bval      = 1'b0;
    rpt       = 1'b0;
    deliv     = 1'b0;
    serr      = 1'b0;
    priority if (item.operation == irpw_pkg::OP_HANDOVER) begin
      flags_nxt.pending = 1'b1;
    end else if (item.timer_wrapped || (e > cfg.agc_max)) begin
      serr   = 1'b1;
      resync = 1'b1;
    end else if ((e > cfg.agc_min) && !item.pin_level) begin
      flags_nxt.phase = irpw_pkg::PH_SPACE;
      restart         = 1'b1;
    end else if (flags.phase == irpw_pkg::PH_SPACE) begin
      priority if (item.pin_level && (e < cfg.space_max) && (e > cfg.space_min)) begin
        cnt_nxt         = '0;
        flags_nxt.done  = 1'b0;
        flags_nxt.phase = irpw_pkg::PH_DATA;
        restart         = 1'b1;
      end else if (item.pin_level) begin
        rpt = 1'b1;
        if (flags.pending) begin
          deliv             = 1'b1;
          flags_nxt.pending = 1'b0;
        end
        resync = 1'b1;
      end else begin
        restart = 1'b1;
      end
    end else if (flags.phase != irpw_pkg::PH_DATA) begin
      restart = 1'b1;
    end else if (cnt >= CW'(FRAME_BITS)) begin
      flags_nxt.done = 1'b1;
      restart        = 1'b1;
    end else begin
      priority if (glitch) begin
        mark_nxt = e_w;
      end else if (!item.pin_level) begin
        restart = 1'b1;
      end else if ((e < cfg.bit_max) && (e > cfg.bit_split)) begin
        if (!flags.done) begin
          frame_nxt[pos] = 1'b1;
          cnt_nxt        = cnt + CW'(1);
          bvalid         = 1'b1;
          bval           = 1'b1;
        end
        restart = 1'b1;
      end else if ((e < cfg.bit_split) && (e > cfg.bit_min)) begin
        if (!flags.done) begin
          frame_nxt[pos] = 1'b0;
          cnt_nxt        = cnt + CW'(1);
          bvalid         = 1'b1;
        end
        restart = 1'b1;
      end else begin
        serr   = 1'b1;
        resync = 1'b1;
      end
    end
    if (resync) begin
      flags_nxt.phase = irpw_pkg::PH_BURST;
      restart         = 1'b1;
    end
    if (restart) begin
      mark_nxt = '0;
    end
  end

  assign cnt_x   = XW'(cnt_nxt);
  assign frame_x = FW'(frame_nxt);

  always_comb begin
    result.restart_timer    = restart;
    result.bit_valid        = bvalid;
    result.bit_value        = bval;
    result.bit_total        = cnt_x[irpw_pkg::BIT_TOTAL_W-1:0];
    result.frame_done       = flags_nxt.done;
    result.frame_word       = frame_x[irpw_pkg::WORD_W-1:0];
    result.repeat_seen      = rpt;
    result.repeat_delivered = deliv;
    result.sync_error       = serr;
    result.receiver_phase   = flags_nxt.phase;
  end

endmodule

`default_nettype wire

>>> rtl/ir_pulse_width_frame_decoder.sv
// Top level of the IR pulse-width frame decoder: input register, receiver state,
// result register and configuration port. Depends on irpw_pkg, irpw_cfg, irpw_step.
//
//   Channel   Ports                         Beat content
//   --------  ----------------------------  ------------------------------------
//   input     in_valid / in_ready / in_data  one edge event or handover request
//   result    out_valid/out_ready/out_data   one decode result per input beat
//   config    cfg_psel ... cfg_pready        eight 16-bit registers at 4*i
//
// One beat is accepted per cycle while the result side is not stalled; a result beat
// reaches out_data through the input register, then the result register.
// The receiver state is updated in the same cycle that writes the result register.
// rst_n is synchronous and active low; it resets control state and config registers.
// A stalled result holds the result register; the input register then fills and
// in_ready drops until out_ready frees the result register.
`default_nettype none

module ir_pulse_width_frame_decoder #(
  parameter int FRAME_BITS = irpw_pkg::FRAME_BITS_DEF,
  parameter int TIME_BITS  = irpw_pkg::TIME_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire irpw_pkg::in_t               in_data,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      irpw_pkg::out_t              out_data,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [irpw_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [irpw_pkg::APB_DW-1:0] cfg_pwdata,
  output      logic [irpw_pkg::APB_DW-1:0] cfg_prdata,
  output      logic                        cfg_pready
);

  localparam int EW = (TIME_BITS < irpw_pkg::ELAPSED_W) ? TIME_BITS : irpw_pkg::ELAPSED_W;
  localparam int SW = ((FRAME_BITS + 7) / 8) * 8;
  localparam int CW = $clog2(FRAME_BITS + 1);

  irpw_pkg::cfg_t   cfg;

  // Input register stage.
  logic             s1_valid_r;
  irpw_pkg::in_t    s1_data_r;
  logic             s1_go;

  // Result register stage.
  logic             out_valid_r;
  irpw_pkg::out_t   out_data_r;

  // Receiver state.
  irpw_pkg::flags_t flags_r;
  logic [CW-1:0]    cnt_r;
  logic [SW-1:0]    frame_r;
  logic [EW-1:0]    mark_r;

  irpw_pkg::flags_t flags_nxt;
  logic [CW-1:0]    cnt_nxt;
  logic [SW-1:0]    frame_nxt;
  logic [EW-1:0]    mark_nxt;
  irpw_pkg::out_t   result;

  // The APB port never inserts wait states.
  assign cfg_pready = 1'b1;

  irpw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  irpw_step #(
    .FRAME_BITS (FRAME_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_step (
    .item      (s1_data_r),
    .cfg       (cfg),
    .flags     (flags_r),
    .cnt       (cnt_r),
    .frame     (frame_r),
    .mark      (mark_r),
    .flags_nxt (flags_nxt),
    .cnt_nxt   (cnt_nxt),
    .frame_nxt (frame_nxt),
    .mark_nxt  (mark_nxt),
    .result    (result)
  );

  // The held beat moves on whenever the result register is empty or being drained,
  // so the input register can take a new beat in that same cycle.
  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      cnt_r       <= '0;
      frame_r     <= '0;
      mark_r      <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
        cnt_r       <= cnt_nxt;
        frame_r     <= frame_nxt;
        mark_r      <= mark_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_go) begin
      out_data_r <= result;
    end
  end

endmodule

`default_nettype wire

>>> rtl/irpw_checker.sv
// Port-level checker for the IR pulse-width frame decoder, bound to the top level.
// Depends on irpw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module irpw_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire irpw_pkg::out_t out_data
);

  // A waiting result beat must hold.
  `IRPW_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "result beat changed while stalled")

  // Reset empties the result register.
  `IRPW_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // A stored bit only happens in data phase and always restarts the timer.
  `IRPW_ASSERT(a_bit_in_data, clk, rst_n, (out_valid && out_data.bit_valid) |-> (out_data.restart_timer && (out_data.receiver_phase == irpw_pkg::PH_DATA)), "bit stored outside data phase")

  // A sync error always drops back to burst wait with a timer restart.
  `IRPW_ASSERT(a_serr_resync, clk, rst_n, (out_valid && out_data.sync_error) |-> (out_data.restart_timer && (out_data.receiver_phase == irpw_pkg::PH_BURST)), "sync error without resync")

  // Handover of a repeat requires the repeat to be seen in the same beat.
  `IRPW_ASSERT(a_deliv_rpt, clk, rst_n, (out_valid && out_data.repeat_delivered) |-> (out_data.repeat_seen && !out_data.bit_valid), "repeat delivered without repeat")

endmodule

bind ir_pulse_width_frame_decoder irpw_checker u_irpw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

>>> verif/ir_pulse_width_frame_decoder_tb.sv
// Self-checking testbench for the IR pulse-width frame decoder top level.
// Depends on irpw_pkg and ir_pulse_width_frame_decoder; drives edge beats and
// APB writes, and checks every result beat against its own decoder model.
module ir_pulse_width_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import irpw_pkg::*;

  localparam int FRAME_BITS = FRAME_BITS_DEF;

  // Clock, reset and the signals the testbench drives. Every input of the
  // block starts at a known value.
  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  in_t                 in_data     = '0;
  logic                out_ready   = 1'b0;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr   = '0;
  logic [APB_DW-1:0]   cfg_pwdata  = '0;

  logic                in_ready;
  logic                out_valid;
  out_t                out_data;
  logic [APB_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  ir_pulse_width_frame_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 2 ns period: high for 1 ns, low for 1 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Edge beats waiting to be driven, and the decode results the model has
  // worked out for beats that were already accepted, oldest first.
  in_t  edge_backlog[$];
  out_t predicted_results[$];

  int   issued          = 0;  // beats placed in the backlog so far
  int   results_checked = 0;  // result beats matched against a prediction
  int   mismatches      = 0;
  bit   calm            = 1'b0;  // when set, neither side inserts idle cycles

  // Model copy of the register file and of the receiver state.
  logic [REG_W-1:0]       cfg_regs [8];
  logic [PHASE_W-1:0]     rx_phase   = PH_BURST;
  logic [BIT_TOTAL_W-1:0] rx_bits    = '0;
  logic                   rx_done    = 1'b0;
  logic [WORD_W-1:0]      rx_frame   = '0;
  logic [ELAPSED_W-1:0]   rx_mark    = '0;
  logic                   rx_pending = 1'b0;

  // Decoder model: applies one accepted beat to the model state and returns
  // the result beat the block must produce for it.
  task automatic decode_edge(input in_t beat, output out_t res);
    logic [ELAPSED_W-1:0] e;
    logic [ELAPSED_W-1:0] gap;
    logic                 restart;
    logic                 resync;
    logic                 bit_val;
    begin
      e       = beat.elapsed;
      res     = '0;
      restart = 1'b0;
      resync  = 1'b0;
      bit_val = 1'b0;
      if (beat.operation == OP_HANDOVER) begin
        rx_pending = 1'b1;
      end else if (beat.timer_wrapped || e > cfg_regs[REG_AGC_MAX]) begin
        res.sync_error = 1'b1;
        resync         = 1'b1;
      end else if (e > cfg_regs[REG_AGC_MIN] && !beat.pin_level) begin
        // A leading burst restarts the frame from any phase.
        rx_phase = PH_SPACE;
        restart  = 1'b1;
      end else if (rx_phase == PH_SPACE) begin
        if (beat.pin_level && e < cfg_regs[REG_SPACE_MAX] && e > cfg_regs[REG_SPACE_MIN]) begin
          rx_bits  = '0;
          rx_done  = 1'b0;
          rx_phase = PH_DATA;
          restart  = 1'b1;
        end else if (beat.pin_level) begin
          // Any other space after the burst is a repeat code.
          res.repeat_seen = 1'b1;
          if (rx_pending) begin
            res.repeat_delivered = 1'b1;
            rx_pending           = 1'b0;
          end
          resync = 1'b1;
        end else begin
          restart = 1'b1;
        end
      end else if (rx_phase != PH_DATA) begin
        restart = 1'b1;
      end else if (rx_bits >= FRAME_BITS) begin
        rx_done = 1'b1;
        restart = 1'b1;
      end else begin
        gap = e - rx_mark;
        if (gap < cfg_regs[REG_GLITCH_LIMIT]) begin
          rx_mark = e;
        end else if (!beat.pin_level) begin
          restart = 1'b1;
        end else if ((e < cfg_regs[REG_BIT_MAX] && e > cfg_regs[REG_BIT_SPLIT]) ||
                     (e < cfg_regs[REG_BIT_SPLIT] && e > cfg_regs[REG_BIT_MIN])) begin
          bit_val = (e > cfg_regs[REG_BIT_SPLIT]);
          if (!rx_done) begin
            // MSB-first within each byte: bit index i lands at 8*(i/8) + 7 - i%8.
            rx_frame[{rx_bits[4:3], ~rx_bits[2:0]}] = bit_val;
            rx_bits       = rx_bits + 1'b1;
            res.bit_valid = 1'b1;
            res.bit_value = bit_val;
          end
          restart = 1'b1;
        end else begin
          res.sync_error = 1'b1;
          resync         = 1'b1;
        end
      end
      if (resync) begin
        rx_phase = PH_BURST;
        restart  = 1'b1;
      end
      if (restart) begin
        rx_mark = '0;
      end
      res.restart_timer  = restart;
      res.bit_total      = rx_bits;
      res.frame_done     = rx_done;
      res.frame_word     = rx_frame;
      res.receiver_phase = rx_phase;
    end
  endtask

  // Input driver. A beat is taken from the backlog when the channel is free and no
  // random idle cycle is drawn; valid stays high with a stable payload until in_ready accepts it.
  // The model is stepped at the acceptance edge, so each prediction is queued
  // in the order the block sees the beats.
  always @(posedge clk) begin : input_driver
    out_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_edge(in_data, res);
        predicted_results.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (edge_backlog.size() != 0 && (calm || $urandom_range(99, 0) >= 8)) begin
          in_valid <= 1'b1;
          in_data  <= edge_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result monitor. Each accepted result beat is compared field by field with
  // the oldest prediction; out_ready stalls at random outside calm stretches.
  always @(posedge clk) begin : result_monitor
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("restart_timer", want.restart_timer, out_data.restart_timer);
          check_field("bit_valid", want.bit_valid, out_data.bit_valid);
          check_field("bit_value", want.bit_value, out_data.bit_value);
          check_field("bit_total", want.bit_total, out_data.bit_total);
          check_field("frame_done", want.frame_done, out_data.frame_done);
          check_field("frame_word", want.frame_word, out_data.frame_word);
          check_field("repeat_seen", want.repeat_seen, out_data.repeat_seen);
          check_field("repeat_delivered", want.repeat_delivered, out_data.repeat_delivered);
          check_field("sync_error", want.sync_error, out_data.sync_error);
          check_field("receiver_phase", want.receiver_phase, out_data.receiver_phase);
          results_checked++;
        end
      end
      out_ready <= calm || ($urandom_range(99, 0) >= 8);
    end
  end

  // APB write: setup cycle, then access until pready. The register takes the
  // value at the edge where psel, penable, pwrite and pready are all high.
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {{(APB_DW-REG_W){1'b0}}, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_regs[idx] = val;
  endtask

  task automatic load_settings(input cfg_t s);
    reg_write(REG_GLITCH_LIMIT, s.glitch_limit);
    reg_write(REG_AGC_MIN, s.agc_min);
    reg_write(REG_AGC_MAX, s.agc_max);
    reg_write(REG_SPACE_MIN, s.space_min);
    reg_write(REG_SPACE_MAX, s.space_max);
    reg_write(REG_BIT_MIN, s.bit_min);
    reg_write(REG_BIT_SPLIT, s.bit_split);
    reg_write(REG_BIT_MAX, s.bit_max);
  endtask

  task automatic push_item(input logic op, input int e, input logic wrapped, input logic pin);
    in_t beat;
    beat.operation     = op;
    beat.elapsed       = e[ELAPSED_W-1:0];
    beat.timer_wrapped = wrapped;
    beat.pin_level     = pin;
    edge_backlog.push_back(beat);
    issued++;
  endtask

  // Random value in the closed range [lo, hi], or lo when the range is empty.
  function automatic int pick_closed(input int lo, input int hi);
    if (hi <= lo) return lo;
    return int'($urandom_range(hi, lo));
  endfunction

  // Random value strictly between lo and hi, or lo when no such value exists.
  function automatic int pick_open(input int lo, input int hi);
    if (hi - lo < 2) return lo;
    return int'($urandom_range(hi - 1, lo + 1));
  endfunction

  function automatic int reg_val(input logic [REG_IDX_W-1:0] idx);
    return int'(cfg_regs[idx]);
  endfunction

  // One mark (pin low) followed by one data space, sometimes after a glitch.
  task automatic push_bit_pair(input bit one);
    int glitch;
    int mark_hi;
    glitch  = reg_val(REG_GLITCH_LIMIT);
    mark_hi = glitch + 2 * reg_val(REG_BIT_SPLIT);
    if (mark_hi > reg_val(REG_AGC_MIN)) mark_hi = reg_val(REG_AGC_MIN);
    if (glitch > 0 && $urandom_range(99, 0) < 5)
      push_item(OP_EDGE, pick_closed(0, glitch - 1), 1'b0, 1'($urandom_range(1, 0)));
    push_item(OP_EDGE, pick_closed(glitch, mark_hi), 1'b0, 1'b0);
    if (one)
      push_item(OP_EDGE, pick_open(reg_val(REG_BIT_SPLIT), reg_val(REG_BIT_MAX)), 1'b0, 1'b1);
    else
      push_item(OP_EDGE, pick_open(reg_val(REG_BIT_MIN), reg_val(REG_BIT_SPLIT)), 1'b0, 1'b1);
  endtask

  task automatic push_burst();
    push_item(OP_EDGE, pick_closed(reg_val(REG_AGC_MIN) + 1, reg_val(REG_AGC_MAX)), 1'b0, 1'b0);
  endtask

  // Burst, start space and nbits data bits. A spoiled frame ends in an error
  // or an interruption; a full frame is followed by a few edges past the end.
  task automatic push_frame(input int nbits, input bit spoil);
    int k;
    int agc_max;
    push_burst();
    push_item(OP_EDGE, pick_open(reg_val(REG_SPACE_MIN), reg_val(REG_SPACE_MAX)), 1'b0, 1'b1);
    for (k = 0; k < nbits; k++) push_bit_pair(1'($urandom_range(1, 0)));
    if (spoil) begin
      agc_max = reg_val(REG_AGC_MAX);
      case ($urandom_range(4, 0))
        0: push_item(OP_EDGE, reg_val(REG_BIT_SPLIT), 1'b0, 1'b1);
        1: push_item(OP_EDGE, $urandom_range(65535, 0), 1'b1, 1'($urandom_range(1, 0)));
        2: begin
          if (agc_max < 65535) push_item(OP_EDGE, pick_closed(agc_max + 1, 65535), 1'b0, 1'b1);
          else push_item(OP_EDGE, 0, 1'b1, 1'b0);
        end
        3: push_item(OP_EDGE, pick_closed(reg_val(REG_BIT_MAX), agc_max), 1'b0, 1'b1);
        default: push_burst();
      endcase
    end else if (nbits >= FRAME_BITS) begin
      for (k = $urandom_range(3, 1); k > 0; k--) push_bit_pair(1'($urandom_range(1, 0)));
    end
  endtask

  // Burst and a space outside the start window, sometimes after a handover.
  task automatic push_repeat();
    if ($urandom_range(1, 0) != 0) push_item(OP_HANDOVER, $urandom_range(65535, 0), 1'b0, 1'b0);
    push_burst();
    if ($urandom_range(1, 0) != 0)
      push_item(OP_EDGE, pick_closed(0, reg_val(REG_SPACE_MIN)), 1'b0, 1'b1);
    else
      push_item(OP_EDGE, pick_closed(reg_val(REG_SPACE_MAX), reg_val(REG_AGC_MAX)), 1'b0, 1'b1);
  endtask

  task automatic push_noise();
    push_item(1'($urandom_range(1, 0)), $urandom_range(65535, 0),
              1'($urandom_range(7, 0) == 0), 1'($urandom_range(1, 0)));
  endtask

  // Mostly well-formed frames with random content, plus repeats, handovers,
  // broken frames and plain noise.
  task automatic run_random(input int count, input bit noise_only);
    int start;
    int pick;
    start = issued;
    while (issued - start < count) begin
      pick = noise_only ? 99 : $urandom_range(99, 0);
      if (pick < 55) push_frame(FRAME_BITS, 1'b0);
      else if (pick < 70) push_frame($urandom_range(FRAME_BITS - 1, 0), 1'b1);
      else if (pick < 82) push_repeat();
      else if (pick < 86) push_item(OP_HANDOVER, $urandom_range(65535, 0),
                                    1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
      else push_noise();
    end
  endtask

  // Registers may only change while nothing is in flight, so each phase ends
  // by waiting until every issued beat has come back and been checked.
  task automatic wait_drained();
    while (results_checked != issued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random register set kept in a sensible order, so that frames can form.
  function automatic cfg_t random_settings();
    cfg_t s;
    s.glitch_limit = 16'($urandom_range(300, 0));
    s.bit_min      = s.glitch_limit + 16'($urandom_range(500, 50));
    s.bit_split    = s.bit_min + 16'($urandom_range(2000, 200));
    s.bit_max      = s.bit_split + 16'($urandom_range(4000, 200));
    s.space_min    = s.bit_max + 16'($urandom_range(2000, 0));
    s.space_max    = s.space_min + 16'($urandom_range(10000, 500));
    s.agc_min      = s.space_max + 16'($urandom_range(3000, 0));
    s.agc_max      = s.agc_min + 16'($urandom_range(20000, 100));
    return s;
  endfunction

  initial begin : stimulus
    cfg_t defaults;
    cfg_t scaled;
    defaults = '{RST_GLITCH_LIMIT, RST_AGC_MIN, RST_AGC_MAX, RST_SPACE_MIN,
                 RST_SPACE_MAX, RST_BIT_MIN, RST_BIT_SPLIT, RST_BIT_MAX};
    scaled   = '{16'd50, 16'd2000, 16'd3000, 16'd800, 16'd2000, 16'd60, 16'd300, 16'd800};
    cfg_regs[REG_GLITCH_LIMIT] = RST_GLITCH_LIMIT;
    cfg_regs[REG_AGC_MIN]      = RST_AGC_MIN;
    cfg_regs[REG_AGC_MAX]      = RST_AGC_MAX;
    cfg_regs[REG_SPACE_MIN]    = RST_SPACE_MIN;
    cfg_regs[REG_SPACE_MAX]    = RST_SPACE_MAX;
    cfg_regs[REG_BIT_MIN]      = RST_BIT_MIN;
    cfg_regs[REG_BIT_SPLIT]    = RST_BIT_SPLIT;
    cfg_regs[REG_BIT_MAX]      = RST_BIT_MAX;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset values written back explicitly. It walks
    // the edge cases one by one: timeouts, repeat with and without a pending
    // handover, window bounds, a glitch in data and a bad bit length.
    load_settings(defaults);
    push_item(OP_EDGE, 0, 1'b0, 1'b0);            // idle edge in wait-for-burst
    push_item(OP_HANDOVER, 65535, 1'b1, 1'b1);    // handover, other fields ignored
    push_item(OP_EDGE, 100, 1'b1, 1'b0);          // timer overflow
    push_item(OP_EDGE, 65535, 1'b0, 1'b1);        // interval above agc_max
    push_item(OP_EDGE, 24001, 1'b0, 1'b0);        // shortest burst
    push_item(OP_EDGE, 5000, 1'b0, 1'b1);         // repeat, handover delivered
    push_item(OP_EDGE, 33000, 1'b0, 1'b0);        // longest burst, no timeout
    push_item(OP_EDGE, 9000, 1'b0, 1'b1);         // start window is exclusive: repeat
    push_item(OP_EDGE, 30000, 1'b0, 1'b0);        // burst
    push_item(OP_EDGE, 1000, 1'b0, 1'b0);         // falling edge while waiting for space
    push_item(OP_EDGE, 23999, 1'b0, 1'b1);        // longest start space
    push_item(OP_EDGE, 399, 1'b0, 1'b1);          // glitch moves the mark
    push_item(OP_EDGE, 1000, 1'b0, 1'b0);         // mark
    push_item(OP_EDGE, 1500, 1'b0, 1'b1);         // zero bit
    push_item(OP_EDGE, 500, 1'b0, 1'b0);
    push_item(OP_EDGE, 3001, 1'b0, 1'b1);         // shortest one bit
    push_item(OP_EDGE, 500, 1'b0, 1'b0);
    push_item(OP_EDGE, 8999, 1'b0, 1'b1);         // longest one bit
    push_item(OP_EDGE, 500, 1'b0, 1'b0);
    push_item(OP_EDGE, 601, 1'b0, 1'b1);          // shortest zero bit
    push_item(OP_EDGE, 500, 1'b0, 1'b0);
    push_item(OP_EDGE, 3000, 1'b0, 1'b1);         // split value is neither bit
    push_item(OP_EDGE, 24000, 1'b0, 1'b0);        // not quite a burst
    push_item(OP_EDGE, 24001, 1'b0, 1'b1);        // long interval ending a space
    wait_drained();

    // Long stretch at full rate on both sides with the reset settings.
    calm = 1'b1;
    run_random(150, 1'b0);
    wait_drained();
    calm = 1'b0;

    load_settings(scaled);
    run_random(100, 1'b0);
    wait_drained();

    repeat (2) begin
      load_settings(random_settings());
      run_random(60, 1'b0);
      wait_drained();
    end

    // Register extremes: everything times out, or nothing ever does.
    load_settings('0);
    run_random(30, 1'b1);
    wait_drained();
    load_settings('1);
    run_random(30, 1'b1);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is far shorter than this.
  initial begin : watchdog
    #400_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/irpw_pkg.sv
rtl/irpw_cfg.sv
rtl/irpw_step.sv
rtl/ir_pulse_width_frame_decoder.sv
rtl/irpw_checker.sv
verif/ir_pulse_width_frame_decoder_tb.sv
